/* src/lcg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_pkg
// Shared types, request codes and jump coefficient tables for the LCG block.
// ----------------------------------------------------------------------------
package lcg_pkg;

    localparam int STATE_W = 32;
    localparam int OUT_W   = 15;
    localparam int REQ_W   = 2;
    localparam int IDX_W   = 5;
    localparam int NJUMP   = 32;

    localparam logic [REQ_W-1:0] REQ_SEED = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DRAW = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SKIP = 2'd2;

    localparam logic [STATE_W-1:0] STATE_RESET = 32'd1;

    // entry k advances the state by 2^k steps; entry 0 is the plain step
    localparam logic [STATE_W-1:0] JUMP_MUL [NJUMP] = '{
        32'd1103515245, 32'd3265436265, 32'd3993403153, 32'd3487424289,
        32'd1601471041, 32'd2335052929, 32'd1979738369, 32'd387043841,
        32'd3194463233, 32'd3722397697, 32'd1073647617, 32'd2432507905,
        32'd1710899201, 32'd3690233857, 32'd4159242241, 32'd4023517185,
        32'd3752067073, 32'd3209166849, 32'd2123366401, 32'd4246732801,
        32'd4198498305, 32'd4102029313, 32'd3909091329, 32'd3523215361,
        32'd2751463425, 32'd1207959553, 32'd2415919105, 32'd536870913,
        32'd1073741825, 32'd2147483649, 32'd1,          32'd1
    };

    localparam logic [STATE_W-1:0] JUMP_ADD [NJUMP] = '{
        32'd12345,      32'd3554416254, 32'd3596950572, 32'd3441282840,
        32'd1695770928, 32'd1680572000, 32'd422948032,  32'd3058047360,
        32'd519516928,  32'd530212352,  32'd2246364160, 32'd646551552,
        32'd3088265216, 32'd472276992,  32'd3897344000, 32'd2425978880,
        32'd556990464,  32'd1113980928, 32'd2227961856, 32'd160956416,
        32'd321912832,  32'd643825664,  32'd1287651328, 32'd2575302656,
        32'd855638016,  32'd1711276032, 32'd3422552064, 32'd2550136832,
        32'd805306368,  32'd1610612736, 32'd3221225472, 32'd2147483648
    };

    typedef struct packed {
        logic             load_seed;
        logic             load_count;
        logic             shift_count;
        logic             mul_en;
        logic             add_en;
        logic             out_load;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_bit0;
        logic out_busy;
    } sts_t;

endpackage
`default_nettype wire

/* src/lcg_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_datapath
// State register, registered multiply and add stage, skip count and result
// register.
// ----------------------------------------------------------------------------
module lcg_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lcg_pkg::cmd_t                 cmd,
    output lcg_pkg::sts_t                      sts,
    input  wire logic [lcg_pkg::STATE_W-1:0]   operand,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [lcg_pkg::OUT_W-1:0]          m_random_value
);

    logic [lcg_pkg::STATE_W-1:0]   state_reg, state_next;
    logic [lcg_pkg::STATE_W-1:0]   count_reg;
    logic [lcg_pkg::STATE_W-1:0]   prod_reg;
    logic [2*lcg_pkg::STATE_W-1:0] prod_full;
    logic [lcg_pkg::OUT_W-1:0]     out_reg;
    logic                          out_valid_reg;

    assign prod_full  = {{lcg_pkg::STATE_W{1'b0}}, state_reg}
                      * {{lcg_pkg::STATE_W{1'b0}}, lcg_pkg::JUMP_MUL[cmd.idx]};
    assign state_next = prod_reg + lcg_pkg::JUMP_ADD[cmd.idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lcg_pkg::STATE_RESET;
        end else if (cmd.load_seed) begin
            state_reg <= operand;
        end else if (cmd.add_en) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= prod_full[lcg_pkg::STATE_W-1:0];
        end
        if (cmd.load_count) begin
            count_reg <= operand;
        end else if (cmd.shift_count) begin
            count_reg <= {1'b0, count_reg[lcg_pkg::STATE_W-1:1]};
        end
        if (cmd.out_load) begin
            out_reg <= state_next[30:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.count_zero = (count_reg == '0);
    assign sts.count_bit0 = count_reg[0];
    assign sts.out_busy   = out_valid_reg && !m_ready;

    assign m_valid        = out_valid_reg;
    assign m_random_value = out_reg;

endmodule
`default_nettype wire

/* src/lcg_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_ctrl
// Request decode and sequencing of draws and skip-ahead walks.
// ----------------------------------------------------------------------------
module lcg_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [lcg_pkg::REQ_W-1:0]   req_type,
    output lcg_pkg::cmd_t                    cmd,
    input  wire lcg_pkg::sts_t               sts
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_ADD  = 2'd3;

    logic [1:0]                state_reg, state_next;
    logic [lcg_pkg::IDX_W-1:0] k_reg, k_next;
    logic                      draw_reg, draw_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            draw_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            draw_reg  <= draw_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        draw_next  = draw_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.idx    = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    k_next = '0;
                    if (req_type == lcg_pkg::REQ_SEED) begin
                        cmd.load_seed = 1'b1;
                    end else if (req_type == lcg_pkg::REQ_DRAW) begin
                        draw_next  = 1'b1;
                        state_next = ST_MUL;
                    end else if (req_type == lcg_pkg::REQ_SKIP) begin
                        draw_next      = 1'b0;
                        cmd.load_count = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (sts.count_zero) begin
                    state_next = ST_IDLE;
                end else if (sts.count_bit0) begin
                    state_next = ST_MUL;
                end else begin
                    cmd.shift_count = 1'b1;
                    k_next          = k_reg + 1'b1;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                if (draw_reg) begin
                    // hold until the result register is free
                    if (!sts.out_busy) begin
                        cmd.add_en   = 1'b1;
                        cmd.out_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.add_en      = 1'b1;
                    cmd.shift_count = 1'b1;
                    k_next          = k_reg + 1'b1;
                    state_next      = ST_SCAN;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* src/lcg_random_with_skip_ahead.sv */
// draw: accept, multiply, then add and load; the add waits while a result is still unread
// seed: loaded on accept; unused request code: accepted, no effect
// skip: scans the count from bit 0, one count bit a step, multiply and add per set bit,
//   on one shared 32x32 multiplier and a registered add; requests wait until idle again
// reset (aresetn low, synchronous): state = 1, no result pending, controller idle
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_random_with_skip_ahead
// 32-bit linear congruential generator with seed load, draw and skip-ahead.
// ----------------------------------------------------------------------------
module lcg_random_with_skip_ahead (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [lcg_pkg::REQ_W-1:0]   s_req_type,
    input  wire logic [lcg_pkg::STATE_W-1:0] s_operand,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [lcg_pkg::OUT_W-1:0]        m_random_value
);

    lcg_pkg::cmd_t cmd;
    lcg_pkg::sts_t sts;

    lcg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .req_type (s_req_type),
        .cmd      (cmd),
        .sts      (sts)
    );

    lcg_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .operand        (s_operand),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_random_value (m_random_value)
    );

endmodule
`default_nettype wire
